// File: rtl/core/cda_pkg.sv
// Shared types, constants and calendar tables for the date arithmetic block.
package cda_pkg;

  // Largest legal year
  localparam int unsigned MAX_YEAR = 9999;

  // Field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned ERR_W   = 2;

  // Working width of day counts: serial numbers plus a signed offset
  localparam int unsigned SER_W = 25;

  // Restoring conversion: 6 steps of 400 years, 2 of 100, 5 of 4, 2 of 1
  localparam int unsigned NUM_STEPS = 15;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned QBITS_W   = 9;
  localparam int unsigned MONTHS    = 12;

  localparam int DIFF_MAX = 4194303;
  localparam int DIFF_MIN = -4194304;
  // last serial day of year MAX_YEAR
  localparam int LAST_DAY = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                            + MAX_YEAR / 400 - 1;

  localparam logic signed [SER_W-1:0] SER_DIFF_MAX = SER_W'(DIFF_MAX);
  localparam logic signed [SER_W-1:0] SER_DIFF_MIN = SER_W'(DIFF_MIN);
  localparam logic signed [SER_W-1:0] SER_LAST     = SER_W'(LAST_DAY);

  typedef enum logic {
    OP_SHIFT = 1'b0,
    OP_DIFF  = 1'b1
  } cda_op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_DATE  = 2'd1,
    ERR_RANGE = 2'd2
  } cda_err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FWD,
    ST_DOY,
    ST_DIFF,
    ST_OFFS,
    ST_RANGE,
    ST_INV,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } cda_state_e;

  // Sequencer position, seen by the datapath
  typedef struct packed {
    cda_state_e              state;
    logic [STEP_W-1:0]       step;
    logic                    conv_b;
  } cda_seq_t;

  // Datapath status, seen by the sequencer
  typedef struct packed {
    logic pre_ok;
    logic day_ok;
    logic op_diff;
    logic range_ok;
    logic month_take;
    logic out_free;
  } cda_stat_t;

  // Years covered by one conversion step
  function automatic logic [SER_W-1:0] step_years(input logic [STEP_W-1:0] k);
    logic [SER_W-1:0] v;
    v = '0;
    case (k)
      4'd0:    v = SER_W'(400 * 32);
      4'd1:    v = SER_W'(400 * 16);
      4'd2:    v = SER_W'(400 * 8);
      4'd3:    v = SER_W'(400 * 4);
      4'd4:    v = SER_W'(400 * 2);
      4'd5:    v = SER_W'(400);
      4'd6:    v = SER_W'(100 * 2);
      4'd7:    v = SER_W'(100);
      4'd8:    v = SER_W'(4 * 16);
      4'd9:    v = SER_W'(4 * 8);
      4'd10:   v = SER_W'(4 * 4);
      4'd11:   v = SER_W'(4 * 2);
      4'd12:   v = SER_W'(4);
      4'd13:   v = SER_W'(2);
      4'd14:   v = SER_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Days covered by one conversion step
  function automatic logic [SER_W-1:0] step_days(input logic [STEP_W-1:0] k);
    logic [SER_W-1:0] v;
    v = '0;
    case (k)
      4'd0:    v = SER_W'(146097 * 32);
      4'd1:    v = SER_W'(146097 * 16);
      4'd2:    v = SER_W'(146097 * 8);
      4'd3:    v = SER_W'(146097 * 4);
      4'd4:    v = SER_W'(146097 * 2);
      4'd5:    v = SER_W'(146097);
      4'd6:    v = SER_W'(36524 * 2);
      4'd7:    v = SER_W'(36524);
      4'd8:    v = SER_W'(1461 * 16);
      4'd9:    v = SER_W'(1461 * 8);
      4'd10:   v = SER_W'(1461 * 4);
      4'd11:   v = SER_W'(1461 * 2);
      4'd12:   v = SER_W'(1461);
      4'd13:   v = SER_W'(365 * 2);
      4'd14:   v = SER_W'(365);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Leap year from the quotient bits of the century, 4-year and year stages:
  // year index in cycle is 100b + 4c + e, the year is leap when e is 3 and the
  // year is not a century end, unless it also closes the 400-year cycle.
  function automatic logic is_leap(input logic [QBITS_W-1:0] q);
    logic [1:0] b;
    logic [4:0] c;
    logic [1:0] e;
    b = q[8:7];
    c = q[6:2];
    e = q[1:0];
    return (e == 2'd3) && ((c != 5'd24) || (b == 2'd3));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] v;
    v = '0;
    case (m)
      4'd2:                              v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:           v = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                      v = 5'd31;
      default:                           v = '0;
    endcase
    return v;
  endfunction

  // Days before the first of month m in a common year
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] v;
    v = '0;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/cda_alu.sv
// Shared subtract-compare and add unit used by every sequencer step.
module cda_alu
  import cda_pkg::*;
(
  input  logic signed [SER_W-1:0] sub_a_i,
  input  logic signed [SER_W-1:0] sub_b_i,
  input  logic signed [SER_W-1:0] add_a_i,
  input  logic signed [SER_W-1:0] add_b_i,
  output logic signed [SER_W-1:0] sub_y_o,
  output logic signed [SER_W-1:0] rest_y_o,
  output logic                    ge_o,
  output logic signed [SER_W-1:0] add_y_o
);

  // compare by subtraction, restoring form keeps a when a < b
  assign sub_y_o  = sub_a_i - sub_b_i;
  assign ge_o     = ~sub_y_o[SER_W-1];
  assign rest_y_o = ge_o ? sub_y_o : sub_a_i;

  // accumulate
  assign add_y_o = add_a_i + add_b_i;

endmodule

// File: rtl/core/cda_seq.sv
// Sequencer: walks conversion steps, month steps and the handshake states.
module cda_seq
  import cda_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  cda_stat_t stat_i,
  output cda_seq_t  seq_o,
  output logic      in_ready_o,
  output logic      out_load_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  cda_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              conv_b_q, conv_b_d;

  // next state
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    conv_b_d = conv_b_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        step_d   = '0;
        conv_b_d = 1'b0;
        state_d  = stat_i.pre_ok ? ST_FWD : ST_DONE;
      end
      ST_FWD: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_DOY;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DOY: begin
        step_d = '0;
        if (!stat_i.day_ok) begin
          state_d = ST_DONE;
        end else if (conv_b_q) begin
          state_d = ST_DIFF;
        end else if (stat_i.op_diff) begin
          conv_b_d = 1'b1;
          state_d  = ST_FWD;
        end else begin
          state_d = ST_OFFS;
        end
      end
      ST_DIFF:  state_d = ST_DONE;
      ST_OFFS:  state_d = ST_RANGE;
      ST_RANGE: begin
        step_d  = '0;
        state_d = stat_i.range_ok ? ST_INV : ST_DONE;
      end
      ST_INV: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_YEAR;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_YEAR:  state_d = ST_MONTH;
      ST_MONTH: begin
        if (!stat_i.month_take) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    out_load_o   = (state_q == ST_DONE) && stat_i.out_free;
    seq_o.state  = state_q;
    seq_o.step   = step_q;
    seq_o.conv_b = conv_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      conv_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      conv_b_q <= conv_b_d;
    end
  end

  // step counter stays inside the conversion table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   step_q <= LAST_STEP)
    else $error("conversion step beyond table");

endmodule

// File: rtl/core/calendar_date_arithmetic.sv
// Top level: input latch, datapath registers, sequencer, shared unit, output register.
//
// Gregorian date arithmetic, one result item per input item. A difference runs
// a field check step, two 15-step date conversions each closed by a day-of-year
// step, a subtract step and an output load step. A shift runs the field check,
// one forward conversion, an offset add, a range check, a 15-step reverse
// conversion, a year step and a month walk of one to twelve steps.
// An item with an illegal date finishes at the field check when a field is out
// of range, after the day-of-year step of date A when the day of date A is past
// its month end and after that of date B when the day of date B is. A shift
// whose date leaves the year range finishes at the range check. All of these
// steps run on one shared subtract-compare and add unit under the sequencer,
// so the block takes one item at a time: in_ready_o is high only while the
// sequencer is idle. The finished result sits in an output register, so a new
// item is taken while it waits.
module calendar_date_arithmetic
  import cda_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  logic [YEAR_W-1:0]         year_a_i,
  input  logic [MONTH_W-1:0]        month_a_i,
  input  logic [DAY_W-1:0]          day_a_i,
  input  logic [YEAR_W-1:0]         year_b_i,
  input  logic [MONTH_W-1:0]        month_b_i,
  input  logic [DAY_W-1:0]          day_b_i,
  input  logic signed [DIFF_W-1:0]  day_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [YEAR_W-1:0]         year_out_o,
  output logic [MONTH_W-1:0]        month_out_o,
  output logic [DAY_W-1:0]          day_out_o,
  output logic signed [DIFF_W-1:0]  day_difference_o,
  output logic [ERR_W-1:0]          error_code_o
);

  cda_seq_t  seq;
  cda_stat_t stat;
  logic      out_load;
  logic      in_fire;

  // latched item
  cda_op_e                    op_q;
  logic [YEAR_W-1:0]          ya_q, yb_q;
  logic [MONTH_W-1:0]         ma_q, mb_q;
  logic [DAY_W-1:0]           da_q, db_q;
  logic signed [DIFF_W-1:0]   off_q;

  // working registers
  logic signed [SER_W-1:0]    rem_q, rem_d;
  logic signed [SER_W-1:0]    acc_q, acc_d;
  logic signed [SER_W-1:0]    sa_q, sa_d;
  logic [QBITS_W-1:0]         qbits_q, qbits_d;
  logic [YEAR_W-1:0]          yr_q, yr_d;
  logic signed [DIFF_W-1:0]   diff_q, diff_d;
  cda_err_e                   err_q, err_d;

  // output register
  logic                       out_valid_q;
  logic [YEAR_W-1:0]          year_out_q;
  logic [MONTH_W-1:0]         month_out_q;
  logic [DAY_W-1:0]           day_out_q;
  logic signed [DIFF_W-1:0]   diff_out_q;
  cda_err_e                   err_out_q;

  // shared unit
  logic signed [SER_W-1:0]    sub_a, sub_b, add_a, add_b;
  logic signed [SER_W-1:0]    sub_y, rest_y, add_y;
  logic                       ge;

  // date under conversion
  logic [MONTH_W-1:0]         cur_m;
  logic [DAY_W-1:0]           cur_d;
  logic                       leap;
  logic signed [SER_W-1:0]    doy;
  logic                       a_pre_ok, b_pre_ok;
  logic [MONTH_W-1:0]         cur_month;

  assign in_fire = in_valid_i && in_ready_o;

  cda_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .seq_o      (seq),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load)
  );

  cda_alu u_alu (
    .sub_a_i  (sub_a),
    .sub_b_i  (sub_b),
    .add_a_i  (add_a),
    .add_b_i  (add_b),
    .sub_y_o  (sub_y),
    .rest_y_o (rest_y),
    .ge_o     (ge),
    .add_y_o  (add_y)
  );

  // field checks that do not need the leap rule
  assign a_pre_ok = (ya_q != '0) && (32'(ya_q) <= MAX_YEAR) && (ma_q != '0)
                    && (32'(ma_q) <= MONTHS) && (da_q != '0);
  assign b_pre_ok = (yb_q != '0) && (32'(yb_q) <= MAX_YEAR) && (mb_q != '0)
                    && (32'(mb_q) <= MONTHS) && (db_q != '0);

  assign cur_m     = seq.conv_b ? mb_q : ma_q;
  assign cur_d     = seq.conv_b ? db_q : da_q;
  assign leap      = is_leap(qbits_q);
  assign cur_month = acc_q[MONTH_W-1:0];

  // zero-based day of year of the date under conversion
  assign doy = SER_W'(days_before_month(cur_m))
               + SER_W'((32'(cur_m) > 2) && leap)
               + SER_W'(cur_d) - SER_W'(1);

  // status to the sequencer
  always_comb begin
    stat.pre_ok     = a_pre_ok && ((op_q == OP_SHIFT) || b_pre_ok);
    stat.day_ok     = (cur_d <= month_days(cur_m, leap));
    stat.op_diff    = (op_q == OP_DIFF);
    stat.range_ok   = ge && !rem_q[SER_W-1];
    stat.month_take = ge && (32'(cur_month) != MONTHS);
    stat.out_free   = !out_valid_q || out_ready_i;
  end

  // operand selection for the shared unit
  always_comb begin
    sub_a = rem_q;
    sub_b = '0;
    add_a = acc_q;
    add_b = '0;
    case (seq.state)
      ST_CHECK: begin
        sub_a = SER_W'(ya_q);
        sub_b = SER_W'(1);
      end
      ST_FWD: begin
        sub_b = step_years(seq.step);
        add_b = step_days(seq.step);
      end
      ST_INV: begin
        sub_b = step_days(seq.step);
        add_b = step_years(seq.step);
      end
      ST_DOY: begin
        sub_a = SER_W'(yb_q);
        sub_b = SER_W'(1);
        add_b = doy;
      end
      ST_DIFF: begin
        sub_a = sa_q;
        sub_b = acc_q;
      end
      ST_OFFS: begin
        add_a = sa_q;
        add_b = SER_W'(off_q);
      end
      ST_RANGE: begin
        sub_a = SER_LAST;
        sub_b = rem_q;
      end
      ST_YEAR: begin
        add_b = SER_W'(1);
      end
      ST_MONTH: begin
        sub_b = SER_W'(month_days(cur_month, leap));
        add_b = SER_W'(1);
      end
      default: begin
        sub_b = '0;
      end
    endcase
  end

  // working register updates
  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    sa_d    = sa_q;
    qbits_d = qbits_q;
    yr_d    = yr_q;
    diff_d  = diff_q;
    err_d   = err_q;
    case (seq.state)
      ST_CHECK: begin
        rem_d  = sub_y;
        acc_d  = '0;
        diff_d = '0;
        err_d  = stat.pre_ok ? ERR_NONE : ERR_DATE;
      end
      ST_FWD, ST_INV: begin
        rem_d   = rest_y;
        acc_d   = ge ? add_y : acc_q;
        qbits_d = {qbits_q[QBITS_W-2:0], ge};
      end
      ST_DOY: begin
        if (!stat.day_ok) begin
          err_d = ERR_DATE;
        end
        if (seq.conv_b) begin
          acc_d = add_y;
        end else begin
          sa_d  = add_y;
          rem_d = sub_y;
          acc_d = '0;
        end
      end
      ST_DIFF: begin
        if (sub_y > SER_DIFF_MAX) begin
          diff_d = DIFF_W'(SER_DIFF_MAX);
          err_d  = ERR_RANGE;
        end else if (sub_y < SER_DIFF_MIN) begin
          diff_d = DIFF_W'(SER_DIFF_MIN);
          err_d  = ERR_RANGE;
        end else begin
          diff_d = DIFF_W'(sub_y);
        end
      end
      ST_OFFS: begin
        rem_d = add_y;
      end
      ST_RANGE: begin
        acc_d = '0;
        if (!stat.range_ok) begin
          err_d = ERR_RANGE;
        end
      end
      ST_YEAR: begin
        yr_d  = add_y[YEAR_W-1:0];
        acc_d = SER_W'(1);
      end
      ST_MONTH: begin
        if (stat.month_take) begin
          rem_d = sub_y;
          acc_d = add_y;
        end
      end
      default: begin
        err_d = err_q;
      end
    endcase
  end

  // item latch and working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= cda_op_e'(operation_i);
      ya_q  <= year_a_i;
      ma_q  <= month_a_i;
      da_q  <= day_a_i;
      yb_q  <= year_b_i;
      mb_q  <= month_b_i;
      db_q  <= day_b_i;
      off_q <= day_offset_i;
    end
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    sa_q    <= sa_d;
    qbits_q <= qbits_d;
    yr_q    <= yr_d;
    diff_q  <= diff_d;
    err_q   <= err_d;
  end

  // output register payload: a good shift gives the new date, else date A
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if ((op_q == OP_SHIFT) && (err_q == ERR_NONE)) begin
        year_out_q  <= yr_q;
        month_out_q <= cur_month;
        day_out_q   <= DAY_W'(rem_q + SER_W'(1));
      end else begin
        year_out_q  <= ya_q;
        month_out_q <= ma_q;
        day_out_q   <= da_q;
      end
      diff_out_q <= diff_q;
      err_out_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign year_out_o       = year_out_q;
  assign month_out_o      = month_out_q;
  assign day_out_o        = day_out_q;
  assign day_difference_o = diff_out_q;
  assign error_code_o     = err_out_q;

  // one item at a time: an accepted item closes the input until it is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_fire |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // the month walk never leaves January to December
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (seq.state == ST_MONTH) |->
                   (cur_month != '0) && (32'(cur_month) <= MONTHS))
    else $error("month walk out of range");

  // a good shift result is a real calendar date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_load && (op_q == OP_SHIFT) && (err_q == ERR_NONE)) |=>
                   (month_out_o != '0) && (32'(month_out_o) <= MONTHS)
                   && (day_out_o != '0) && (year_out_o != '0))
    else $error("shift produced an impossible date");

endmodule

// File: verif/tb_calendar_date_arithmetic.sv
// Self-checking testbench for the Gregorian date shift and difference block.
module tb_calendar_date_arithmetic;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int     RANDOM_ITEMS = 1700;
  localparam int     QUIET_LIMIT  = 3000;  // cycles without any handshake
  localparam int     DRAIN_CYCLES = 60;    // longer than the slowest shift
  localparam int     HOLD_AFTER   = 100;   // items taken before the long output stall
  localparam int     HOLD_CYCLES  = 400;
  localparam longint YEAR_LIMIT   = longint'(MAX_YEAR);

  typedef struct {
    cda_op_e                   op;
    logic [YEAR_W-1:0]         year_a;
    logic [MONTH_W-1:0]        month_a;
    logic [DAY_W-1:0]          day_a;
    logic [YEAR_W-1:0]         year_b;
    logic [MONTH_W-1:0]        month_b;
    logic [DAY_W-1:0]          day_b;
    logic signed [DIFF_W-1:0]  offset;
  } date_item_t;

  typedef struct {
    logic [YEAR_W-1:0]         year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic signed [DIFF_W-1:0]  diff;
    cda_err_e                  err;
  } date_result_t;

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_ready_o;
  logic                      operation_i      = 1'b0;
  logic [YEAR_W-1:0]         year_a_i         = '0;
  logic [MONTH_W-1:0]        month_a_i        = '0;
  logic [DAY_W-1:0]          day_a_i          = '0;
  logic [YEAR_W-1:0]         year_b_i         = '0;
  logic [MONTH_W-1:0]        month_b_i        = '0;
  logic [DAY_W-1:0]          day_b_i          = '0;
  logic signed [DIFF_W-1:0]  day_offset_i     = '0;
  logic                      out_valid_o;
  logic                      out_ready_i      = 1'b0;
  logic [YEAR_W-1:0]         year_out_o;
  logic [MONTH_W-1:0]        month_out_o;
  logic [DAY_W-1:0]          day_out_o;
  logic signed [DIFF_W-1:0]  day_difference_o;
  logic [ERR_W-1:0]          error_code_o;

  date_item_t   items_to_send[$];
  date_result_t dates_due[$];

  int item_total    = 0;
  int items_taken   = 0;
  int shifts_taken  = 0;
  int diffs_taken   = 0;
  int fail_cnt      = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int results_by_code[3] = '{0, 0, 0};

  calendar_date_arithmetic dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .year_a_i        (year_a_i),
    .month_a_i       (month_a_i),
    .day_a_i         (day_a_i),
    .year_b_i        (year_b_i),
    .month_b_i       (month_b_i),
    .day_b_i         (day_b_i),
    .day_offset_i    (day_offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .day_difference_o(day_difference_o),
    .error_code_o    (error_code_o)
  );

  // Calendar arithmetic on plain integers
  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_length(longint y, longint m);
    case (m)
      2:                      return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:            return 30;
      1, 3, 5, 7, 8, 10, 12:  return 31;
      default:                return 0;
    endcase
  endfunction

  function automatic bit legal_date(longint y, longint m, longint d);
    if (y < 1 || y > YEAR_LIMIT || m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(y, m));
  endfunction

  // days from 0001-01-01 to January 1 of year y
  function automatic longint days_to_year(longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint serial_day(longint y, longint m, longint d);
    longint n;
    n = days_to_year(y);
    for (longint k = 1; k < m; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  // Expected result of one item
  function automatic date_result_t predict_date_result(date_item_t it);
    date_result_t r;
    longint       off, n, last_day, yy, mm, rem, delta;
    r.year  = it.year_a;
    r.month = it.month_a;
    r.day   = it.day_a;
    r.diff  = '0;
    r.err   = ERR_NONE;
    off     = it.offset;
    if (!legal_date(it.year_a, it.month_a, it.day_a) ||
        (it.op == OP_DIFF && !legal_date(it.year_b, it.month_b, it.day_b))) begin
      r.err = ERR_DATE;
    end else if (it.op == OP_SHIFT) begin
      n        = serial_day(it.year_a, it.month_a, it.day_a) + off;
      last_day = days_to_year(YEAR_LIMIT + 1) - 1;
      if (n < 0 || n > last_day) begin
        r.err = ERR_RANGE;
      end else begin
        yy = n / 366 + 1;
        while (days_to_year(yy + 1) <= n) yy++;
        rem = n - days_to_year(yy);
        mm  = 1;
        while (mm < 12 && rem >= month_length(yy, mm)) begin
          rem -= month_length(yy, mm);
          mm++;
        end
        r.year  = YEAR_W'(yy);
        r.month = MONTH_W'(mm);
        r.day   = DAY_W'(rem + 1);
      end
    end else begin
      delta = serial_day(it.year_a, it.month_a, it.day_a) -
              serial_day(it.year_b, it.month_b, it.day_b);
      if (delta > DIFF_MAX) begin
        delta = DIFF_MAX;
        r.err = ERR_RANGE;
      end else if (delta < DIFF_MIN) begin
        delta = DIFF_MIN;
        r.err = ERR_RANGE;
      end
      r.diff = DIFF_W'(delta);
    end
    return r;
  endfunction

  task automatic add_item(cda_op_e op, int ya, int ma, int da, int yb, int mb, int db,
                          int off);
    date_item_t it;
    it.op      = op;
    it.year_a  = YEAR_W'(ya);
    it.month_a = MONTH_W'(ma);
    it.day_a   = DAY_W'(da);
    it.year_b  = YEAR_W'(yb);
    it.month_b = MONTH_W'(mb);
    it.day_b   = DAY_W'(db);
    it.offset  = DIFF_W'(off);
    items_to_send.push_back(it);
  endtask

  // Legal date, biased toward the ends of the year range and month ends
  task automatic random_date(output int y, output int m, output int d);
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)       y = $urandom_range(3, 1);
    else if (pick < 10) y = $urandom_range(MAX_YEAR, MAX_YEAR - 2);
    else                y = $urandom_range(MAX_YEAR, 1);
    m = $urandom_range(12, 1);
    if ($urandom_range(4) == 0) d = int'(month_length(y, m));
    else                        d = $urandom_range(int'(month_length(y, m)), 1);
  endtask

  // Mostly legal dates; a few broken ones and some raw noise
  task automatic add_random_item();
    int      ya, ma, da, yb, mb, db, off, pick;
    cda_op_e op;
    op   = $urandom_range(1) ? OP_DIFF : OP_SHIFT;
    pick = $urandom_range(99);
    if (pick < 12) begin
      add_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      random_date(ya, ma, da);
      random_date(yb, mb, db);
      if (pick < 18) begin
        // break one field of one date
        case ($urandom_range(5))
          0:       da = int'(month_length(ya, ma)) + 1;
          1:       ma = $urandom_range(1) ? 13 : 0;
          2:       ya = $urandom_range(1) ? MAX_YEAR + 1 : 0;
          3:       db = int'(month_length(yb, mb)) + 1;
          4:       mb = $urandom_range(15, 13);
          default: db = 0;
        endcase
      end
      pick = $urandom_range(9);
      if (pick < 4)      off = int'($urandom_range(80)) - 40;
      else if (pick < 7) off = int'($urandom_range(6000)) - 3000;
      else if (pick < 9) off = int'($urandom_range(800000)) - 400000;
      else               off = $urandom;
      add_item(op, ya, ma, da, yb, mb, db, off);
    end
  endtask

  // Idle percentages move through three phases as items are taken
  function automatic int send_idle_pct();
    if (items_taken < item_total / 3)     return 37;
    if (items_taken < 2 * item_total / 3) return 58;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (items_taken < item_total / 3)     return 58;
    if (items_taken < 2 * item_total / 3) return 37;
    return 0;
  endfunction

  task automatic compare_date_result(date_result_t r);
    if (year_out_o !== r.year) begin
      $error("year_out: expected %0d, got %0d", r.year, year_out_o);
      fail_cnt++;
    end
    if (month_out_o !== r.month) begin
      $error("month_out: expected %0d, got %0d", r.month, month_out_o);
      fail_cnt++;
    end
    if (day_out_o !== r.day) begin
      $error("day_out: expected %0d, got %0d", r.day, day_out_o);
      fail_cnt++;
    end
    if (day_difference_o !== r.diff) begin
      $error("day_difference: expected %0d, got %0d", r.diff, day_difference_o);
      fail_cnt++;
    end
    if (error_code_o !== r.err) begin
      $error("error_code: expected %0d, got %0d", r.err, error_code_o);
      fail_cnt++;
    end
  endtask

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Input driver: presents the head of the queue, keeps it until taken
  always @(posedge clk_i) begin : feed_items
    date_item_t head;
    logic       offering;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        head = items_to_send.pop_front();
        dates_due.push_back(predict_date_result(head));
        if (head.op == OP_SHIFT) shifts_taken++;
        else                     diffs_taken++;
        items_taken <= items_taken + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          head = items_to_send[0];
          operation_i  <= head.op;
          year_a_i     <= head.year_a;
          month_a_i    <= head.month_a;
          day_a_i      <= head.day_a;
          year_b_i     <= head.year_b;
          month_b_i    <= head.month_b;
          day_b_i      <= head.day_b;
          day_offset_i <= head.offset;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result, drives ready with random stalls
  always @(posedge clk_i) begin : check_results
    date_result_t r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (dates_due.size() == 0) begin
          $error("result with no item outstanding: year %0d month %0d day %0d",
                 year_out_o, month_out_o, day_out_o);
          fail_cnt++;
        end else begin
          r = dates_due.pop_front();
          compare_date_result(r);
          results_by_code[r.err]++;
        end
      end
      // one long stall so the output register fills and input backs up
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && items_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Cycles since the last handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_calendar_date_arithmetic: errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    // year and month wraps, leap rules
    add_item(OP_SHIFT, 2023, 12, 31, 0, 0, 0, 1);
    add_item(OP_SHIFT, 2000, 1, 1, 0, 0, 0, -1);
    add_item(OP_SHIFT, 2024, 3, 1, 1, 1, 1, -1);
    add_item(OP_SHIFT, 1900, 2, 28, 1, 1, 1, 1);
    add_item(OP_DIFF, 2000, 2, 29, 1900, 3, 1, 0);
    add_item(OP_DIFF, 1900, 2, 29, 1, 1, 1, 0);
    add_item(OP_SHIFT, 2001, 2, 29, 1, 1, 1, 5);
    // shifts at and past the ends of the year range, offset extremes
    add_item(OP_SHIFT, 1, 1, 1, 0, 0, 0, -1);
    add_item(OP_SHIFT, MAX_YEAR, 12, 31, 0, 0, 0, 1);
    add_item(OP_SHIFT, 1, 1, 1, 0, 0, 0, 3652058);
    add_item(OP_SHIFT, MAX_YEAR, 12, 31, 0, 0, 0, -3652058);
    add_item(OP_SHIFT, 5000, 6, 15, 0, 0, 0, DIFF_MAX);
    add_item(OP_SHIFT, 5000, 6, 15, 0, 0, 0, DIFF_MIN);
    // differences across the full range, offset ignored
    add_item(OP_DIFF, MAX_YEAR, 12, 31, 1, 1, 1, DIFF_MIN);
    add_item(OP_DIFF, 1, 1, 1, MAX_YEAR, 12, 31, DIFF_MAX);
    add_item(OP_DIFF, 1234, 5, 6, 1234, 5, 6, 0);
    // illegal fields in date A
    add_item(OP_SHIFT, 0, 1, 1, 0, 0, 0, 1);
    add_item(OP_SHIFT, MAX_YEAR + 1, 1, 1, 0, 0, 0, 1);
    add_item(OP_SHIFT, 16383, 15, 31, 16383, 15, 31, -1);
    add_item(OP_SHIFT, 2020, 0, 10, 0, 0, 0, 1);
    add_item(OP_SHIFT, 2020, 13, 10, 0, 0, 0, 1);
    add_item(OP_SHIFT, 2020, 4, 31, 0, 0, 0, 1);
    add_item(OP_SHIFT, 2020, 4, 0, 0, 0, 0, 1);
    // date B checked for difference only
    add_item(OP_DIFF, 2020, 4, 30, 2020, 6, 31, 0);
    add_item(OP_DIFF, 2020, 4, 30, 16383, 15, 31, 0);
    add_item(OP_SHIFT, 2020, 4, 30, 16383, 15, 31, 0);

    repeat (RANDOM_ITEMS) add_random_item();
    item_total = items_to_send.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_to_send.size() == 0);
    wait (dates_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (dates_due.size() != 0) begin
      $error("%0d results never arrived", dates_due.size());
      fail_cnt++;
    end
    $display("Run covered %0d items: %0d shifts, %0d differences, one %0d-cycle output stall.",
             items_taken, shifts_taken, diffs_taken, HOLD_CYCLES);
    $display("Result codes seen: %0d ok, %0d illegal date, %0d out of range; %0d mismatches.",
             results_by_code[ERR_NONE], results_by_code[ERR_DATE],
             results_by_code[ERR_RANGE], fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_calendar_date_arithmetic: clean");
    end else begin
      $display("tb_calendar_date_arithmetic: errors");
    end
    $finish;
  end

endmodule
